FILE: rtl/core/cypd_pkg.sv
// ----------------------------------------------------------------------------
// cypd_pkg: shared types and constants of the camera direction block
// Q formats, configuration register indexes, CORDIC arctangent table.
// ----------------------------------------------------------------------------
package cypd_pkg;

  localparam int ANGLE_WIDTH_DEF     = 16;
  localparam int VECTOR_WIDTH_DEF    = 16;
  localparam int TRIG_ITERATIONS_DEF = 14;

  localparam int CFG_IDX_WIDTH = 2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_PITCH = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_PITCH = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_YAW   = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_YAW   = 2'd3;
  localparam int CFG_ADDR_WIDTH = 8;

  // Q30 working values
  localparam int QW = 36;
  localparam logic signed [QW-1:0] Q30_ONE     = 36'sd1073741824;
  localparam logic signed [QW-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [QW-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [QW-1:0] CORDIC_GAIN = 36'sd652032874;

  // arctangent of 2^-i in Q30
  function automatic logic signed [QW-1:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'h3243F6A8;   5'd1: v = 32'h1DAC6705;
      5'd2: v = 32'h0FADBAFC;   5'd3: v = 32'h07F56EA6;
      5'd4: v = 32'h03FEAB76;   5'd5: v = 32'h01FFD55B;
      5'd6: v = 32'h00FFFAAA;   5'd7: v = 32'h007FFF55;
      5'd8: v = 32'h003FFFEA;   5'd9: v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;  5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;  5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;  5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;  5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;  5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;  5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;  5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;  5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;  5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;  5'd29: v = 32'h00000002;
      default: v = 32'h00000001;
    endcase
    return QW'($signed({1'b0, v}));
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE, ST_REDUCE, ST_ROTATE, ST_MUL, ST_OUT
  } back_state_t;

endpackage

FILE: rtl/core/cypd_if.sv
// ----------------------------------------------------------------------------
// cypd_stream_if: valid/ready channel with a generic payload
// One word moves at a clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface cypd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/cypd_front.sv
// ----------------------------------------------------------------------------
// cypd_front: angle update
// Accepts deltas, applies bounds and pushes the new angles into the queue.
// ----------------------------------------------------------------------------
module cypd_front
  import cypd_pkg::*;
#(
  parameter int AW = ANGLE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [AW-1:0]   delta_yaw,
  input  logic signed [AW-1:0]   delta_pitch,
  input  logic signed [AW-1:0]   min_pitch,
  input  logic signed [AW-1:0]   max_pitch,
  input  logic signed [AW-1:0]   min_yaw,
  input  logic signed [AW-1:0]   max_yaw,
  output logic                   q_push,
  input  logic                   q_full,
  output logic signed [AW-1:0]   q_yaw,
  output logic signed [AW-1:0]   q_pitch
);
  logic signed [AW-1:0] yaw_angle, pitch_angle, yaw_next, pitch_next;
  logic signed [AW:0]   np, ny;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // full width candidates, exclusive bounds
  always_comb begin
    np = (AW+1)'(pitch_angle) - (AW+1)'(delta_pitch);
    ny = (AW+1)'(yaw_angle) + (AW+1)'(delta_yaw);
    yaw_next   = yaw_angle;
    pitch_next = pitch_angle;
    if (delta_yaw != '0 || delta_pitch != '0) begin
      if ((AW+1)'(min_pitch) < np && np < (AW+1)'(max_pitch))
        pitch_next = AW'(np);
      if ((AW+1)'(min_yaw) < ny && ny < (AW+1)'(max_yaw))
        yaw_next = AW'(ny);
      else
        yaw_next = '0;
    end
  end

  assign q_yaw   = yaw_next;
  assign q_pitch = pitch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_angle   <= '0;
      pitch_angle <= '0;
    end else if (q_push) begin
      yaw_angle   <= yaw_next;
      pitch_angle <= pitch_next;
    end
  end
endmodule

FILE: rtl/core/cypd_queue.sv
// ----------------------------------------------------------------------------
// cypd_queue: two-entry angle queue between front and back
// Register based fifo so each side stalls on its own.
// ----------------------------------------------------------------------------
module cypd_queue
  import cypd_pkg::*;
#(
  parameter int W = 2 * ANGLE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         nempty,
  output logic [W-1:0] rdata
);
  logic [W-1:0] mem [2];
  logic         wp, rp;
  logic [1:0]   cnt;

  assign full   = cnt == 2'd2;
  assign nempty = cnt != 2'd0;
  assign rdata  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !nempty |-> !pop)
    else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count out of range");
`endif
endmodule

FILE: rtl/core/cypd_back.sv
// ----------------------------------------------------------------------------
// cypd_back: sine/cosine and front vector
// Yaw and pitch CORDIC rotators step together, then products and rounding.
// ----------------------------------------------------------------------------
module cypd_back
  import cypd_pkg::*;
#(
  parameter int AW = ANGLE_WIDTH_DEF,
  parameter int VW = VECTOR_WIDTH_DEF,
  parameter int NIT = TRIG_ITERATIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_nempty,
  input  logic signed [AW-1:0] q_yaw,
  input  logic signed [AW-1:0] q_pitch,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [VW-1:0] front_x,
  output logic signed [VW-1:0] front_y,
  output logic signed [VW-1:0] front_z,
  output logic signed [AW-1:0] yaw_now,
  output logic signed [AW-1:0] pitch_now
);
  localparam int ITW = $clog2(NIT + 1);
  localparam int PW  = 64;
  localparam int VF  = VW - 2;

  back_state_t state, state_next;
  logic [ITW-1:0] it;
  logic signed [QW-1:0] yx, yy, yz, px, py, pz;
  logic yflip, pflip;
  logic signed [QW-1:0] sy, cy, sp, cp;
  logic signed [PW-1:0] pxs, pzs;
  logic signed [AW-1:0] yaw_r, pitch_r;

  function automatic logic signed [QW-1:0] to_q30(input logic signed [AW-1:0] a);
    return QW'(a) <<< (30 - (AW - 4));
  endfunction

  function automatic logic signed [QW-1:0] clampq(input logic signed [QW-1:0] v);
    if (v > Q30_ONE) return Q30_ONE;
    if (v < -Q30_ONE) return -Q30_ONE;
    return v;
  endfunction

  function automatic logic signed [VW-1:0] rnd(input logic signed [PW-1:0] v,
                                                input int s);
    logic signed [PW-1:0] r, one;
    one = PW'(1) <<< VF;
    r = (v + (PW'(1) <<< (s - 1))) >>> s;
    if (r > one) r = one;
    if (r < -one) r = -one;
    return VW'(r);
  endfunction

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (q_nempty) state_next = ST_REDUCE;
      ST_REDUCE: if (yz <= Q30_HALF_PI && yz >= -Q30_HALF_PI &&
                     pz <= Q30_HALF_PI && pz >= -Q30_HALF_PI) state_next = ST_ROTATE;
      ST_ROTATE: if (it == ITW'(NIT - 1)) state_next = ST_MUL;
      ST_MUL:    state_next = ST_OUT;
      ST_OUT:    if (out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: q_pop = q_nempty;
      ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign sy = clampq(yflip ? -yy : yy);
  assign cy = clampq(yflip ? -yx : yx);
  assign sp = clampq(pflip ? -py : py);
  assign cp = clampq(pflip ? -px : px);

  // datapath: load, reduce by pi, rotate one step a cycle, multiply
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        yz <= to_q30(q_yaw); pz <= to_q30(q_pitch);
        yaw_r <= q_yaw; pitch_r <= q_pitch;
        yx <= CORDIC_GAIN; yy <= '0; px <= CORDIC_GAIN; py <= '0;
        yflip <= 1'b0; pflip <= 1'b0; it <= '0;
      end
      ST_REDUCE: begin
        if (yz > Q30_HALF_PI) begin yz <= yz - Q30_PI; yflip <= ~yflip; end
        else if (yz < -Q30_HALF_PI) begin yz <= yz + Q30_PI; yflip <= ~yflip; end
        if (pz > Q30_HALF_PI) begin pz <= pz - Q30_PI; pflip <= ~pflip; end
        else if (pz < -Q30_HALF_PI) begin pz <= pz + Q30_PI; pflip <= ~pflip; end
      end
      ST_ROTATE: begin
        if (yz >= 0) begin
          yx <= yx - (yy >>> it); yy <= yy + (yx >>> it); yz <= yz - atan_q30(5'(it));
        end else begin
          yx <= yx + (yy >>> it); yy <= yy - (yx >>> it); yz <= yz + atan_q30(5'(it));
        end
        if (pz >= 0) begin
          px <= px - (py >>> it); py <= py + (px >>> it); pz <= pz - atan_q30(5'(it));
        end else begin
          px <= px + (py >>> it); py <= py - (px >>> it); pz <= pz + atan_q30(5'(it));
        end
        it <= it + 1'b1;
      end
      ST_MUL: begin
        // clamped sine/cosine fit in 32 signed bits
        pxs <= PW'($signed(sy[31:0])) * PW'($signed(cp[31:0]));
        pzs <= -(PW'($signed(cy[31:0])) * PW'($signed(cp[31:0])));
        front_y <= rnd(PW'(sp), 30 - VF);
        yaw_now <= yaw_r;
        pitch_now <= pitch_r;
      end
      default: ;
    endcase
  end

  assign front_x = rnd(pxs, 60 - VF);
  assign front_z = rnd(pzs, 60 - VF);

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst) q_pop |-> state == ST_IDLE)
    else $error("pop outside idle");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(yaw_now))
    else $error("result dropped under stall");
  a_iter: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROTATE |-> it < ITW'(NIT))
    else $error("iteration overrun");
`endif
endmodule

FILE: rtl/core/camera_yaw_pitch_direction.sv
// ----------------------------------------------------------------------------
// camera_yaw_pitch_direction: yaw/pitch deltas to unit front vector
// Keeps camera angles and returns the Q1.14 front vector for each step.
// ----------------------------------------------------------------------------
// Channels: in_ch carries delta_yaw/delta_pitch words, out_ch returns one word
// per input with front_x/y/z and the updated angles, cfg_ch writes the four
// bound registers (0 min_pitch, 1 max_pitch, 2 min_yaw, 3 max_yaw); other
// indexes are ignored. Write configuration only while the block is idle.
// The front part updates the angles in the cycle a word is accepted and puts
// them in a two-entry queue. The back part runs two CORDIC rotators for yaw
// and pitch on one iteration counter: load, range reduction by pi, rotation,
// multiply, then the result is held. The back part takes the next queued
// word only after the result of the last one has been taken.
// A stalled receiver holds the result; the queue then fills and in_ch.ready
// drops. Reset clears angles to zero and bounds to their defaults.
// ----------------------------------------------------------------------------
module camera_yaw_pitch_direction
  import cypd_pkg::*;
#(
  parameter int ANGLE_WIDTH     = ANGLE_WIDTH_DEF,
  parameter int VECTOR_WIDTH    = VECTOR_WIDTH_DEF,
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
  input logic clk,
  input logic rst,
  cypd_stream_if.sink   in_ch,
  cypd_stream_if.sink   cfg_ch,
  cypd_stream_if.source out_ch
);
  localparam int AW = ANGLE_WIDTH;

  logic signed [AW-1:0] min_pitch, max_pitch, min_yaw, max_yaw;
  logic q_push, q_full, q_pop, q_nempty;
  logic signed [AW-1:0] f_yaw, f_pitch;
  logic [2*AW-1:0] q_rdata;

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_pitch <= AW'(-6144);
      max_pitch <= AW'(6144);
      min_yaw   <= AW'(-25736);
      max_yaw   <= AW'(25736);
    end else if (cfg_ch.valid) begin
      if (cfg_ch.data.index == CFG_ADDR_WIDTH'(REG_MIN_PITCH))
        min_pitch <= AW'(cfg_ch.data.value);
      if (cfg_ch.data.index == CFG_ADDR_WIDTH'(REG_MAX_PITCH))
        max_pitch <= AW'(cfg_ch.data.value);
      if (cfg_ch.data.index == CFG_ADDR_WIDTH'(REG_MIN_YAW))
        min_yaw <= AW'(cfg_ch.data.value);
      if (cfg_ch.data.index == CFG_ADDR_WIDTH'(REG_MAX_YAW))
        max_yaw <= AW'(cfg_ch.data.value);
    end
  end

  cypd_front #(.AW(AW)) u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .delta_yaw(AW'(in_ch.data.delta_yaw)), .delta_pitch(AW'(in_ch.data.delta_pitch)),
    .min_pitch, .max_pitch, .min_yaw, .max_yaw,
    .q_push, .q_full, .q_yaw(f_yaw), .q_pitch(f_pitch)
  );

  cypd_queue #(.W(2 * AW)) u_queue (
    .clk, .rst, .push(q_push), .wdata({f_yaw, f_pitch}), .full(q_full),
    .pop(q_pop), .nempty(q_nempty), .rdata(q_rdata)
  );

  cypd_back #(.AW(AW), .VW(VECTOR_WIDTH), .NIT(TRIG_ITERATIONS)) u_back (
    .clk, .rst, .q_nempty,
    .q_yaw(q_rdata[2*AW-1:AW]), .q_pitch(q_rdata[AW-1:0]),
    .q_pop, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .front_x(out_ch.data.front_x), .front_y(out_ch.data.front_y),
    .front_z(out_ch.data.front_z), .yaw_now(out_ch.data.yaw_now),
    .pitch_now(out_ch.data.pitch_now)
  );
endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of camera_yaw_pitch_direction
// Sends yaw/pitch delta words and writes the angle bounds. A predictor keeps
// its own angles and bounds, runs a fixed-point CORDIC, and every result word
// is checked field by field in order. Both sides idle at random, and the
// receiver also holds off for one long stretch.
// ----------------------------------------------------------------------------
module tb;
  import cypd_pkg::*;

  typedef struct packed {
    logic signed [15:0] delta_yaw;
    logic signed [15:0] delta_pitch;
  } step_word_t;

  typedef struct packed {
    logic [CFG_ADDR_WIDTH-1:0] index;
    logic signed [15:0]        value;
  } bound_word_t;

  typedef struct packed {
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] yaw_now;
    logic signed [15:0] pitch_now;
  } view_word_t;

  localparam logic [CFG_ADDR_WIDTH-1:0] REG_UNUSED_LO = 8'd4;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_UNUSED_HI = 8'd255;
  localparam int  ROT_STEPS   = 14;
  localparam int  DRAIN_WAIT  = 40;
  localparam int  CYCLE_LIMIT = 600000;
  localparam longint HALF_PI  = 64'sd1686629713;
  localparam longint FULL_PI  = 64'sd3373259426;
  localparam longint ROT_GAIN = 64'sd652032874;
  localparam longint ONE_Q30  = 64'sd1073741824;
  localparam longint ONE_Q14  = 64'sd16384;

  localparam longint ATAN_TAB [ROT_STEPS] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  cypd_stream_if #(.payload_t(step_word_t))  in_ch ();
  cypd_stream_if #(.payload_t(bound_word_t)) cfg_ch ();
  cypd_stream_if #(.payload_t(view_word_t))  out_ch ();

  camera_yaw_pitch_direction i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // predictor state and bound copies
  longint pitch_lo, pitch_hi, yaw_lo, yaw_hi;
  longint cam_yaw, cam_pitch;
  view_word_t view_queue[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;
  int  long_hold = 0;

  function automatic longint limit_one(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint round_up(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // sine and cosine in Q30 of a Q3.12 angle
  function automatic void trig_q30(input longint ang, output longint s,
                                   output longint c);
    longint z, x, y, nx;
    bit flip;
    z = ang * 64'sd262144;
    x = ROT_GAIN;
    y = 0;
    flip = 1'b0;
    while (z > HALF_PI) begin
      z -= FULL_PI;
      flip = !flip;
    end
    while (z < -HALF_PI) begin
      z += FULL_PI;
      flip = !flip;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ATAN_TAB[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = limit_one(x, ONE_Q30);
    s = limit_one(y, ONE_Q30);
  endfunction

  // angle update and front vector for one step word
  function automatic view_word_t camera_step(input step_word_t w);
    longint dy, dp, np, ny, sy, cy, sp, cp;
    view_word_t r;
    dy = longint'(w.delta_yaw);
    dp = longint'(w.delta_pitch);
    if (dy != 0 || dp != 0) begin
      np = cam_pitch - dp;
      ny = cam_yaw + dy;
      if (pitch_lo < np && np < pitch_hi) cam_pitch = np;
      if (yaw_lo < ny && ny < yaw_hi) cam_yaw = ny;
      else cam_yaw = 0;
    end
    trig_q30(cam_yaw, sy, cy);
    trig_q30(cam_pitch, sp, cp);
    r.front_x   = 16'(limit_one(round_up(sy * cp, 46), ONE_Q14));
    r.front_y   = 16'(limit_one(round_up(sp, 16), ONE_Q14));
    r.front_z   = 16'(limit_one(round_up(-(cy * cp), 46), ONE_Q14));
    r.yaw_now   = 16'(cam_yaw);
    r.pitch_now = 16'(cam_pitch);
    return r;
  endfunction

  // send one step word and queue its expected view
  task automatic send_step(input logic [15:0] dy, input logic [15:0] dp);
    step_word_t w;
    w.delta_yaw = dy;
    w.delta_pitch = dp;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    view_queue.push_back(camera_step(w));
    if (send_idle && $urandom_range(3) == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(11)) @(negedge clk);
    end
  endtask

  task automatic drop_step_valid();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // wait until the block has returned everything
  task automatic wait_drained();
    drop_step_valid();
    while (view_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_bound(input logic [CFG_ADDR_WIDTH-1:0] addr,
                             input logic [15:0] val);
    bound_word_t w;
    w.index = addr;
    w.value = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= w;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (addr)
      REG_MIN_PITCH: pitch_lo = longint'($signed(val));
      REG_MAX_PITCH: pitch_hi = longint'($signed(val));
      REG_MIN_YAW:   yaw_lo   = longint'($signed(val));
      REG_MAX_YAW:   yaw_hi   = longint'($signed(val));
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_all_bounds(input logic [15:0] plo, input logic [15:0] phi,
                                  input logic [15:0] ylo, input logic [15:0] yhi);
    write_bound(REG_MIN_PITCH, plo);
    write_bound(REG_MAX_PITCH, phi);
    write_bound(REG_MIN_YAW, ylo);
    write_bound(REG_MAX_YAW, yhi);
  endtask

  // mostly small moves so the angles wander inside the bounds
  task automatic random_steps(input int n);
    int sel;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(9);
      if (sel == 0) send_step(16'd0, 16'd0);
      else if (sel < 3) send_step(16'($urandom), 16'($urandom));
      else send_step(16'($signed($urandom_range(4000)) - 2000),
                     16'($signed($urandom_range(1600)) - 800));
    end
  endtask

  // directed tests
  task automatic test_reset_view();
    send_step(16'd0, 16'd0);
    send_step(16'd0, 16'd0);
  endtask

  task automatic test_field_extremes();
    send_step(16'h7FFF, 16'h0000);
    send_step(16'h8000, 16'h0000);
    send_step(16'h0000, 16'h7FFF);
    send_step(16'h0000, 16'h8000);
    send_step(16'h0001, 16'hFFFF);
    send_step(16'hFFFF, 16'h0001);
    send_step(16'd12000, 16'hEC00);
    send_step(16'd12000, 16'hF000);
    send_step(16'd1736, 16'd5000);
    send_step(16'hFFFF, 16'hFFFF);
    send_step(16'h7FFF, 16'h7FFF);
    send_step(16'h8000, 16'h8000);
  endtask

  task automatic test_bound_settings();
    wait_drained();
    // widest bounds
    write_all_bounds(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_step(16'd30000, 16'h8AD0);
    send_step(16'd2767, 16'd2000);
    send_step(16'd1, 16'd0);
    send_step(16'h8000, 16'h7FFF);
    wait_drained();
    // inverted bounds freeze pitch and zero yaw
    write_all_bounds(16'd100, 16'hFF9C, 16'd200, 16'hFF38);
    send_step(16'd5, 16'hFFFB);
    send_step(16'd0, 16'd0);
    wait_drained();
    // empty bounds
    write_all_bounds(16'd0, 16'd0, 16'd0, 16'd0);
    send_step(16'd3, 16'd3);
    wait_drained();
    // writes to unused indexes change nothing
    write_bound(REG_UNUSED_LO, 16'h1234);
    write_bound(REG_UNUSED_HI, 16'hFFFF);
    write_all_bounds(16'hE800, 16'd6144, 16'h9B78, 16'd25736);
    send_step(16'd100, 16'd0);
    random_steps(10);
  endtask

  task automatic test_random_bounds();
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_all_bounds(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      random_steps(30);
    end
    wait_drained();
    write_all_bounds(16'hE800, 16'd6144, 16'h9B78, 16'd25736);
  endtask

  task automatic test_backpressure();
    long_hold = 300;
    random_steps(20);
  endtask

  task automatic test_random_traffic();
    random_steps(600);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    random_steps(80);
  endtask

  // receiver side: random stalls plus one long hold-off
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        n = long_hold;
        long_hold = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end else if (recv_idle && $urandom_range(4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(11)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    view_word_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (view_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected view word %h", got);
      end else begin
        want = view_queue.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"view mismatch: expected x=%0d y=%0d z=%0d yaw=%0d pitch=%0d,",
                      " got x=%0d y=%0d z=%0d yaw=%0d pitch=%0d"},
                     want.front_x, want.front_y, want.front_z, want.yaw_now,
                     want.pitch_now, got.front_x, got.front_y, got.front_z,
                     got.yaw_now, got.pitch_now);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    pitch_lo = -6144;
    pitch_hi = 6144;
    yaw_lo   = -25736;
    yaw_hi   = 25736;
    cam_yaw  = 0;
    cam_pitch = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_view();
    test_field_extremes();
    test_bound_settings();
    test_random_bounds();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/core/cypd_pkg.sv
rtl/core/cypd_if.sv
rtl/core/cypd_front.sv
rtl/core/cypd_queue.sv
rtl/core/cypd_back.sv
rtl/core/camera_yaw_pitch_direction.sv
sim/tb.sv
